### sv/rdic_pkg.sv
// ----------------------------------------------------------------------------
// rdic_pkg
// shared constants and types of the rom image integrity checker
// ----------------------------------------------------------------------------
package rdic_pkg;

    localparam int MAX_SIZE_LOG2 = 16;
    localparam int SIZE_W        = 5;
    localparam int POS_W         = MAX_SIZE_LOG2;
    localparam int SPAN_W        = MAX_SIZE_LOG2 + 1;
    localparam int LG_W          = $clog2(MAX_SIZE_LOG2 + 1);
    localparam int STORE_AW      = MAX_SIZE_LOG2 - 1;
    localparam int BANK_AW       = STORE_AW - 1;
    localparam int BANK_DEPTH    = 1 << BANK_AW;

    localparam logic [SIZE_W-1:0] SIZE_LOG2_RESET = SIZE_W'(16);
    localparam logic [7:0]        BYTE_ALL_ONES   = 8'hFF;
    localparam logic [7:0]        BYTE_ALL_ZEROS  = 8'h00;

    typedef enum logic [1:0] {
        VERDICT_NONE         = 2'd0,
        VERDICT_HALVES_EQUAL = 2'd1,
        VERDICT_CUT_DUMP     = 2'd2
    } verdict_t;

endpackage

### sv/rom_dump_integrity_check.sv
// ----------------------------------------------------------------------------
// rom_dump_integrity_check
// checks one rom image a byte per transfer: or/and masks, halves identical,
// cut-dump pattern; first half kept in two byte-wide banks (even/odd address)
// ----------------------------------------------------------------------------
// result strobe: done is registered from the s1 stage of the last byte
// throughput: one byte per cycle, busy stays low; the bank reads of a byte
//   are issued at its transfer and compared in the cycle after it
// reset: size_log2 back to 16, or mask and position cleared, and mask and
//   eq/cut flags set; the banks are not cleared and need no clearing pass
// the receiver cannot stall, each result shows for one cycle on done
module rom_dump_integrity_check
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [7:0]                     data_byte,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rdic_pkg::SIZE_W-1:0]    cfg_data,
    output logic                           done,
    output logic [7:0]                     ones_seen,
    output logic [7:0]                     ones_always,
    output logic                           all_fixed,
    output logic [1:0]                     verdict
);

    logic [7:0] bank_even [rdic_pkg::BANK_DEPTH];
    logic [7:0] bank_odd  [rdic_pkg::BANK_DEPTH];

    logic [rdic_pkg::SIZE_W-1:0]   size_log2_reg;
    logic [rdic_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic [7:0]                    or_reg, or_next;
    logic [7:0]                    and_reg, and_next;
    logic                          eq_reg, eq_next;
    logic                          cut_reg, cut_next;

    logic                          s1_valid_reg;
    logic [7:0]                    s1_byte_reg;
    logic                          s1_second_reg;
    logic                          s1_odd_reg;
    logic                          s1_pair_reg;
    logic                          s1_last_reg;
    logic [7:0]                    s1_or_reg;
    logic [7:0]                    s1_and_reg;
    logic [7:0]                    rd_even_reg;
    logic [7:0]                    rd_odd_reg;

    logic                          done_reg;
    logic [7:0]                    ones_seen_reg;
    logic [7:0]                    ones_always_reg;
    logic                          all_fixed_reg;
    rdic_pkg::verdict_t            verdict_reg, verdict_next;

    logic                          accept;
    logic [rdic_pkg::LG_W-1:0]     lg;
    logic [rdic_pkg::SPAN_W-1:0]   size_span;
    logic [rdic_pkg::POS_W-1:0]    half;
    logic                          second;
    logic                          last;
    logic [rdic_pkg::POS_W-1:0]    k_full;
    logic [rdic_pkg::STORE_AW-1:0] k;
    logic                          pair_in;
    logic                          halves_differ;
    logic                          cut_fails;
    logic [7:0]                    loose;

    assign busy      = 1'b0;
    assign cfg_ready = !start && !s1_valid_reg && !done_reg;
    assign accept    = start && !busy;

    assign lg        = (size_log2_reg > rdic_pkg::SIZE_W'(rdic_pkg::MAX_SIZE_LOG2))
                       ? rdic_pkg::LG_W'(rdic_pkg::MAX_SIZE_LOG2)
                       : size_log2_reg[rdic_pkg::LG_W-1:0];
    assign size_span = rdic_pkg::SPAN_W'(1) << lg;
    assign half      = size_span[rdic_pkg::SPAN_W-1:1];
    assign second    = pos_reg >= half;
    assign last      = rdic_pkg::SPAN_W'(pos_reg) >= (size_span - rdic_pkg::SPAN_W'(1));
    assign k_full    = pos_reg - half;
    assign k         = k_full[rdic_pkg::STORE_AW-1:0];
    assign pair_in   = (k_full | rdic_pkg::POS_W'(1)) < half;

    always_comb
    begin
        or_next  = or_reg;
        and_next = and_reg;
        pos_next = pos_reg;
        if (accept)
        begin
            if (last)
            begin
                or_next  = rdic_pkg::BYTE_ALL_ZEROS;
                and_next = rdic_pkg::BYTE_ALL_ONES;
                pos_next = '0;
            end
            else
            begin
                or_next  = or_reg | data_byte;
                and_next = and_reg & data_byte;
                pos_next = pos_reg + rdic_pkg::POS_W'(1);
            end
        end
    end

    // compare stage, in the cycle after the transfer
    always_comb
    begin
        halves_differ = (s1_odd_reg ? rd_odd_reg : rd_even_reg) != s1_byte_reg;
        cut_fails     = s1_pair_reg &&
                        (s1_odd_reg ? (s1_byte_reg != rdic_pkg::BYTE_ALL_ONES)
                                    : (rd_odd_reg != s1_byte_reg));
        eq_next  = eq_reg;
        cut_next = cut_reg;
        if (s1_valid_reg && s1_second_reg)
        begin
            eq_next  = eq_reg && !halves_differ;
            cut_next = cut_reg && !cut_fails;
        end
        loose = s1_or_reg & ~s1_and_reg;
        verdict_next = rdic_pkg::VERDICT_NONE;
        if (loose != rdic_pkg::BYTE_ALL_ZEROS)
        begin
            if (eq_next)
                verdict_next = rdic_pkg::VERDICT_HALVES_EQUAL;
            else if (cut_next)
                verdict_next = rdic_pkg::VERDICT_CUT_DUMP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_log2_reg <= rdic_pkg::SIZE_LOG2_RESET;
            pos_reg       <= '0;
            or_reg        <= rdic_pkg::BYTE_ALL_ZEROS;
            and_reg       <= rdic_pkg::BYTE_ALL_ONES;
            eq_reg        <= 1'b1;
            cut_reg       <= 1'b1;
            s1_valid_reg  <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                size_log2_reg <= cfg_data;
            pos_reg      <= pos_next;
            or_reg       <= or_next;
            and_reg      <= and_next;
            s1_valid_reg <= accept;
            done_reg     <= s1_valid_reg && s1_last_reg;
            if (s1_valid_reg && s1_last_reg)
            begin
                eq_reg  <= 1'b1;
                cut_reg <= 1'b1;
            end
            else
            begin
                eq_reg  <= eq_next;
                cut_reg <= cut_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_byte_reg   <= data_byte;
            s1_second_reg <= second;
            s1_odd_reg    <= k[0];
            s1_pair_reg   <= pair_in;
            s1_last_reg   <= last;
            s1_or_reg     <= or_reg | data_byte;
            s1_and_reg    <= and_reg & data_byte;
        end
        if (s1_valid_reg && s1_last_reg)
        begin
            ones_seen_reg   <= s1_or_reg;
            ones_always_reg <= s1_and_reg;
            all_fixed_reg   <= loose == rdic_pkg::BYTE_ALL_ZEROS;
            verdict_reg     <= verdict_next;
        end
    end

    // first-half banks: written in the first half, read in the second
    always_ff @(posedge clk)
    begin
        if (accept && !second)
        begin
            if (pos_reg[0])
                bank_odd[pos_reg[rdic_pkg::STORE_AW-1:1]] <= data_byte;
            else
                bank_even[pos_reg[rdic_pkg::STORE_AW-1:1]] <= data_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && second)
        begin
            rd_even_reg <= bank_even[k[rdic_pkg::STORE_AW-1:1]];
            rd_odd_reg  <= bank_odd[k[rdic_pkg::STORE_AW-1:1]];
        end
    end

    assign done        = done_reg;
    assign ones_seen   = ones_seen_reg;
    assign ones_always = ones_always_reg;
    assign all_fixed   = all_fixed_reg;
    assign verdict     = verdict_reg;

`ifndef SYNTHESIS
    a_done_follows_last : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(s1_valid_reg && s1_last_reg))
        else $error("result strobe without a last byte");

    a_fixed_forces_none : assert property (@(posedge clk) disable iff (!rst_n)
        (done && all_fixed) |-> (verdict == rdic_pkg::VERDICT_NONE))
        else $error("verdict set although all bits fixed");

    a_fixed_matches_masks : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (all_fixed == ((ones_seen & ~ones_always) == rdic_pkg::BYTE_ALL_ZEROS)))
        else $error("all_fixed disagrees with masks");

    a_pos_cleared_after_last : assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_last_reg) |-> (pos_reg == '0))
        else $error("position not cleared after last byte");
`endif

endmodule
